>>> rtl/core/tet_pkg.sv
package tet_pkg;

   typedef enum logic [2:0] {
      OP_INSERT   = 3'd0,
      OP_RM_TAG   = 3'd1,
      OP_RM_FIRST = 3'd2,
      OP_PEEK     = 3'd3,
      OP_CNT_DATE = 3'd4,
      OP_CLEAR    = 3'd5,
      OP_TOTAL    = 3'd6,
      OP_NONE     = 3'd7
   } op_type;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_DATE  = 3'd1;
   localparam logic [2:0] ST_BAD_TIME  = 3'd2;
   localparam logic [2:0] ST_EMPTY     = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   localparam int StampBits = 32;
   localparam int KeyLsb    = 11;

   typedef struct packed {
      op_type                 op;
      logic [StampBits-1:0]   stamp;
      logic                   date_bad;
      logic                   time_bad;
   } cmd_type;

   function automatic logic [4:0] month_len(input logic [3:0] m);
      logic [4:0] len;
      case (m)
         4'd2:    len = 5'd28;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

>>> rtl/core/timestamped_entry_table_unit.sv
// Insert, clear and total count do not scan the table; remove by tag and count on date
// read the table in one pass, peek in one pass and remove earliest in two. Each pass
// reads the table one entry a cycle. One command is handled at a time; a 2-deep queue
// buffers further items.
// Reset empties the table and the queue; stored entries are not cleared.
module timestamped_entry_table_unit import tet_pkg::*; #(
   parameter int TABLE_DEPTH = 32,
   parameter int TAG_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // tag, day, month, year, hour, minute
   input  logic [2:0]  req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // count, tag_out, day_out, month_out, year_out, hour_out,
                                   // minute_out
   output logic [2:0]  rsp_tuser   // status
);

   logic                q_valid;
   cmd_type             q_cmd;
   logic [TAG_BITS-1:0] q_tag;
   logic                q_pop;

   tet_front #(.TAG_BITS(TAG_BITS)) u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .q_valid, .q_cmd, .q_tag, .q_pop
   );

   tet_back #(.TABLE_DEPTH(TABLE_DEPTH), .TAG_BITS(TAG_BITS)) u_back (
      .clock, .reset, .q_valid, .q_cmd, .q_tag, .q_pop,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

endmodule

>>> rtl/core/tet_front.sv
module tet_front import tet_pkg::*; #(
   parameter int TAG_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [47:0]         req_tdata,
   input  logic [2:0]          req_tuser,
   output logic                q_valid,
   output cmd_type             q_cmd,
   output logic [TAG_BITS-1:0] q_tag,
   input  logic                q_pop
);

   localparam int WideBits = (TAG_BITS > 16) ? TAG_BITS : 16;

   logic [15:0]   f_tag;
   logic [4:0]    f_day;
   logic [3:0]    f_month;
   logic [11:0]   f_year;
   logic [4:0]    f_hour;
   logic [5:0]    f_minute;
   logic [27:0]   prod;
   logic [7:0]    quot;
   logic [12:0]   quot25;
   logic          div25;
   logic          leap;
   logic [5:0]    mlen;
   logic [WideBits-1:0] tag_wide;
   cmd_type       cmd;

   cmd_type             buf_cmd_ff [2];
   logic [TAG_BITS-1:0] buf_tag_ff [2];
   logic                wp_ff;
   logic                rp_ff;
   logic [1:0]          fill_ff;
   logic                push;

   assign f_tag    = req_tdata[15:0];
   assign f_day    = req_tdata[20:16];
   assign f_month  = req_tdata[24:21];
   assign f_year   = req_tdata[36:25];
   assign f_hour   = req_tdata[41:37];
   assign f_minute = req_tdata[47:42];

   always_comb begin
      prod   = 28'(f_year) * 28'd41944;
      quot   = prod[27:20];
      quot25 = {1'b0, quot, 4'b0} + {2'b0, quot, 3'b0} + {5'b0, quot};
      div25  = (13'(f_year) == quot25);
      leap   = ((f_year[1:0] == 2'd0) && !div25) || ((f_year[3:0] == 4'd0) && div25);
      mlen   = 6'(month_len(f_month)) + 6'((f_month == 4'd2) && leap);
      cmd.op       = op_type'(req_tuser);
      cmd.stamp    = {f_year, f_month, f_day, f_hour, f_minute};
      cmd.date_bad = (f_year == 12'd0) || (f_day == 5'd0) || (f_month == 4'd0) ||
                     (f_month > 4'd12) || (6'(f_day) > mlen);
      cmd.time_bad = (f_hour >= 5'd24) || (f_minute >= 6'd60);
      tag_wide     = WideBits'(f_tag);
   end

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (fill_ff != 2'd0);
   assign q_cmd      = buf_cmd_ff[rp_ff];
   assign q_tag      = buf_tag_ff[wp_ff ^ wp_ff ^ rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         buf_cmd_ff[wp_ff] <= cmd;
         buf_tag_ff[wp_ff] <= tag_wide[TAG_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= 1'b0;
         rp_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (q_pop) rp_ff <= !rp_ff;
         fill_ff <= fill_ff + 2'(push) - 2'(q_pop);
      end
   end

endmodule

>>> rtl/core/tet_back.sv
module tet_back import tet_pkg::*; #(
   parameter int TABLE_DEPTH = 32,
   parameter int TAG_BITS    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  cmd_type             q_cmd,
   input  logic [TAG_BITS-1:0] q_tag,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [55:0]         rsp_tdata,
   output logic [2:0]          rsp_tuser
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int XW = (CW > 6) ? CW : 6;
   localparam int WideBits = (TAG_BITS > 16) ? TAG_BITS : 16;

   typedef enum logic [2:0] {
      S_IDLE, S_FIND, S_PACK, S_COUNT, S_DONE
   } state_type;

   state_type state_ff;

   logic [TAG_BITS-1:0]  mem_tag [TABLE_DEPTH];
   logic [StampBits-1:0] mem_stamp [TABLE_DEPTH];
   logic [TAG_BITS-1:0]  rd_tag_ff;
   logic [StampBits-1:0] rd_stamp_ff;

   logic [CW-1:0]        cnt_ff;
   logic [CW-1:0]        issue_ff;
   logic [CW-1:0]        rd_i_ff;
   logic                 rd_v_ff;
   logic [CW-1:0]        wr_n_ff;
   logic [CW-1:0]        hits_ff;
   logic [CW-1:0]        best_idx_ff;
   logic [StampBits-1:0] best_stamp_ff;
   logic [TAG_BITS-1:0]  best_tag_ff;
   op_type               op_ff;
   logic [StampBits-1:0] key_ff;
   logic [TAG_BITS-1:0]  tag_key_ff;
   logic                 show_ff;
   logic [2:0]           status_ff;

   logic                 rsp_valid_ff;
   logic [2:0]           rsp_status_ff;
   logic [5:0]           rsp_count_ff;
   logic [15:0]          rsp_tag_ff;
   logic [StampBits-1:0] rsp_stamp_ff;

   logic                 scanning;
   logic                 rd_en;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [TAG_BITS-1:0]  wr_tag;
   logic [StampBits-1:0] wr_stamp;
   logic                 skip;
   logic                 drained;
   logic                 ins_ok;
   logic [XW-1:0]        hits_x;
   logic [WideBits-1:0]  best_wide;

   assign q_pop    = (state_ff == S_IDLE) && q_valid;
   assign scanning = (state_ff == S_FIND) || (state_ff == S_PACK) || (state_ff == S_COUNT);
   assign rd_en    = scanning && (issue_ff < cnt_ff);
   assign drained  = !rd_en && !rd_v_ff;
   assign skip     = (op_ff == OP_RM_TAG) ? (rd_tag_ff == tag_key_ff) : (rd_i_ff == best_idx_ff);
   assign ins_ok   = !q_cmd.date_bad && !q_cmd.time_bad && (cnt_ff < CW'(TABLE_DEPTH));

   always_comb begin
      if (state_ff == S_IDLE) begin
         wr_en    = q_pop && (q_cmd.op == OP_INSERT) && ins_ok;
         wr_addr  = cnt_ff[AW-1:0];
         wr_tag   = q_tag;
         wr_stamp = q_cmd.stamp;
      end else begin
         wr_en    = (state_ff == S_PACK) && rd_v_ff && !skip;
         wr_addr  = wr_n_ff[AW-1:0];
         wr_tag   = rd_tag_ff;
         wr_stamp = rd_stamp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_tag_ff   <= mem_tag[issue_ff[AW-1:0]];
         rd_stamp_ff <= mem_stamp[issue_ff[AW-1:0]];
      end
      if (wr_en) begin
         mem_tag[wr_addr]   <= wr_tag;
         mem_stamp[wr_addr] <= wr_stamp;
      end
   end

   assign hits_x    = XW'(hits_ff);
   assign best_wide = WideBits'(best_tag_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rd_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         rd_v_ff <= rd_en;
         rd_i_ff <= issue_ff;
         if (rd_en) issue_ff <= issue_ff + 1'b1;
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  op_ff      <= q_cmd.op;
                  key_ff     <= q_cmd.stamp;
                  tag_key_ff <= q_tag;
                  issue_ff   <= '0;
                  wr_n_ff    <= '0;
                  hits_ff    <= '0;
                  show_ff    <= 1'b0;
                  status_ff  <= ST_OK;
                  state_ff   <= S_DONE;
                  case (q_cmd.op)
                     OP_INSERT: begin
                        if (q_cmd.date_bad) status_ff <= ST_BAD_DATE;
                        else if (q_cmd.time_bad) status_ff <= ST_BAD_TIME;
                        else if (!ins_ok) status_ff <= ST_FULL;
                        if (ins_ok) begin
                           cnt_ff  <= cnt_ff + 1'b1;
                           hits_ff <= cnt_ff + 1'b1;
                        end else begin
                           hits_ff <= cnt_ff;
                        end
                     end
                     OP_RM_TAG: state_ff <= S_PACK;
                     OP_RM_FIRST, OP_PEEK: begin
                        if (cnt_ff == '0) status_ff <= ST_EMPTY;
                        else state_ff <= S_FIND;
                     end
                     OP_CNT_DATE: begin
                        if (q_cmd.date_bad) status_ff <= ST_BAD_DATE;
                        else state_ff <= S_COUNT;
                     end
                     OP_CLEAR: cnt_ff <= '0;
                     OP_TOTAL: hits_ff <= cnt_ff;
                     default: ;
                  endcase
               end
            end
            S_FIND: begin
               if (rd_v_ff && ((rd_i_ff == '0) || (rd_stamp_ff < best_stamp_ff))) begin
                  best_stamp_ff <= rd_stamp_ff;
                  best_tag_ff   <= rd_tag_ff;
                  best_idx_ff   <= rd_i_ff;
               end
               if (drained) begin
                  show_ff <= 1'b1;
                  if (op_ff == OP_RM_FIRST) begin
                     issue_ff <= '0;
                     state_ff <= S_PACK;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_PACK: begin
               if (rd_v_ff) begin
                  if (skip) hits_ff <= hits_ff + 1'b1;
                  else wr_n_ff <= wr_n_ff + 1'b1;
               end
               if (drained) begin
                  cnt_ff   <= wr_n_ff;
                  state_ff <= S_DONE;
               end
            end
            S_COUNT: begin
               if (rd_v_ff && (rd_stamp_ff[StampBits-1:KeyLsb] == key_ff[StampBits-1:KeyLsb]))
                  hits_ff <= hits_ff + 1'b1;
               if (drained) state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_count_ff  <= hits_x[5:0];
                  rsp_tag_ff    <= show_ff ? best_wide[15:0] : 16'd0;
                  rsp_stamp_ff  <= show_ff ? best_stamp_ff : '0;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b0, rsp_stamp_ff[5:0], rsp_stamp_ff[10:6], rsp_stamp_ff[31:20],
                        rsp_stamp_ff[19:16], rsp_stamp_ff[15:11], rsp_tag_ff, rsp_count_ff};

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(TABLE_DEPTH)) else $error("entry count above depth");
   a_pack_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PACK) |-> (wr_n_ff <= issue_ff)) else $error("compaction overtook reads");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == S_IDLE)) else $error("queue popped while busy");
   a_done_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && !rsp_tvalid |=> rsp_tvalid) else $error("result not loaded");

endmodule
